// File: design/skvt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Types and fixed field widths shared by the table's cells, its controller
// and its top level.
// ----------------------------------------------------------------------------
package skvt_pkg;

	localparam int REQ_TYPE_W = 2;
	localparam int KEY_W      = 64;
	localparam int VALUE_W    = 64;
	localparam int STATUS_W   = 3;
	localparam int POS_W      = 10;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_FIND   = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_INSERTED  = 3'd0,
		STATUS_DUPLICATE = 3'd1,
		STATUS_FULL      = 3'd2,
		STATUS_FOUND     = 3'd3,
		STATUS_NOT_FOUND = 3'd4,
		STATUS_REMOVED   = 3'd5
	} status_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] found_value;
	} result_t;

	typedef enum logic [1:0] {
		CTRL_IDLE = 2'd0,
		CTRL_CMP  = 2'd1,
		CTRL_ACT  = 2'd2
	} ctrl_state_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} cell_op_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic     cmp_en;
		cell_op_t op;
	} cell_cmd_t;

	// Result decision handed from the controller to the result register.
	typedef struct packed {
		logic    emit;
		status_t status;
		logic    pos_en;
		logic    val_en;
	} act_result_t;

endpackage

// File: design/skvt_cell.sv
// ----------------------------------------------------------------------------
// Sorted key/value table cell
// Holds one table entry, compares it against the broadcast key and shifts
// entries to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module skvt_cell #(
	parameter int KEY_WIDTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  skvt_pkg::cell_cmd_t          cmd,
	input  logic [KEY_WIDTH-1:0]         req_key,
	input  logic [skvt_pkg::VALUE_W-1:0] req_value,
	input  logic [KEY_WIDTH-1:0]         left_key,
	input  logic [skvt_pkg::VALUE_W-1:0] left_value,
	input  logic                         left_occ,
	input  logic                         left_lt,
	input  logic [KEY_WIDTH-1:0]         right_key,
	input  logic [skvt_pkg::VALUE_W-1:0] right_value,
	input  logic                         right_occ,
	output logic [KEY_WIDTH-1:0]         key,
	output logic [skvt_pkg::VALUE_W-1:0] value,
	output logic                         occ,
	output logic                         lt,
	output logic                         eq,
	output logic                         boundary
);

	logic [KEY_WIDTH-1:0]         key_q;
	logic [skvt_pkg::VALUE_W-1:0] value_q;
	logic                         occ_q;
	logic                         lt_q;
	logic                         eq_q;
	logic                         bnd;

	// The occupied prefix is sorted, so the less-than flags form a run of ones
	// followed by zeros; this cell is the boundary when it starts the zeros.
	assign bnd = !lt_q && left_lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			lt_q  <= 1'b0;
			eq_q  <= 1'b0;
		end else begin
			if (cmd.cmp_en) begin
				lt_q <= occ_q && (key_q < req_key);
				eq_q <= occ_q && (key_q == req_key);
			end
			unique case (cmd.op)
				skvt_pkg::OP_INSERT: begin
					if (bnd) begin
						occ_q <= 1'b1;
					end else if (!lt_q) begin
						occ_q <= left_occ;
					end
				end
				skvt_pkg::OP_REMOVE: begin
					if (!lt_q) begin
						occ_q <= right_occ;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			skvt_pkg::OP_INSERT: begin
				if (bnd) begin
					key_q   <= req_key;
					value_q <= req_value;
				end else if (!lt_q) begin
					key_q   <= left_key;
					value_q <= left_value;
				end
			end
			skvt_pkg::OP_REMOVE: begin
				if (!lt_q) begin
					key_q   <= right_key;
					value_q <= right_value;
				end
			end
			default: begin
			end
		endcase
	end

	assign key      = key_q;
	assign value    = value_q;
	assign occ      = occ_q;
	assign lt       = lt_q;
	assign eq       = eq_q;
	assign boundary = bnd;

endmodule

// File: design/skvt_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted key/value table controller
// Sequences compare and act phases, keeps the entry count and decides the
// status of each request.
// ----------------------------------------------------------------------------
module skvt_ctrl #(
	parameter int DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  skvt_pkg::req_type_t   req_type,
	input  logic                  hit,
	output logic                  busy,
	output skvt_pkg::cell_cmd_t   cmd,
	output skvt_pkg::act_result_t act
);

	localparam int CW = $clog2(DEPTH + 1);

	skvt_pkg::ctrl_state_t state_q;
	skvt_pkg::ctrl_state_t state_d;
	logic [CW-1:0]         count_q;
	logic                  full;
	logic                  count_inc;
	logic                  count_dec;

	assign full = (count_q == CW'(DEPTH));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			skvt_pkg::CTRL_IDLE: begin
				if (start) begin
					state_d = skvt_pkg::CTRL_CMP;
				end
			end
			skvt_pkg::CTRL_CMP: begin
				state_d = skvt_pkg::CTRL_ACT;
			end
			skvt_pkg::CTRL_ACT: begin
				state_d = start ? skvt_pkg::CTRL_CMP : skvt_pkg::CTRL_IDLE;
			end
			default: begin
				state_d = skvt_pkg::CTRL_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = (state_q == skvt_pkg::CTRL_CMP);
		cmd.cmp_en = (state_q == skvt_pkg::CTRL_CMP);
		cmd.op     = skvt_pkg::OP_HOLD;
		act.emit   = 1'b0;
		act.status = skvt_pkg::STATUS_NOT_FOUND;
		act.pos_en = 1'b0;
		act.val_en = 1'b0;
		count_inc  = 1'b0;
		count_dec  = 1'b0;
		if (state_q == skvt_pkg::CTRL_ACT) begin
			unique case (req_type)
				skvt_pkg::REQ_INSERT: begin
					act.emit = 1'b1;
					if (hit) begin
						act.status = skvt_pkg::STATUS_DUPLICATE;
						act.pos_en = 1'b1;
					end else if (full) begin
						act.status = skvt_pkg::STATUS_FULL;
					end else begin
						act.status = skvt_pkg::STATUS_INSERTED;
						act.pos_en = 1'b1;
						cmd.op     = skvt_pkg::OP_INSERT;
						count_inc  = 1'b1;
					end
				end
				skvt_pkg::REQ_FIND: begin
					act.emit = 1'b1;
					if (hit) begin
						act.status = skvt_pkg::STATUS_FOUND;
						act.pos_en = 1'b1;
						act.val_en = 1'b1;
					end
				end
				skvt_pkg::REQ_REMOVE: begin
					act.emit = 1'b1;
					if (hit) begin
						act.status = skvt_pkg::STATUS_REMOVED;
						act.pos_en = 1'b1;
						cmd.op     = skvt_pkg::OP_REMOVE;
						count_dec  = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skvt_pkg::CTRL_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (count_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_shift_only_in_act: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op != skvt_pkg::OP_HOLD |-> state_q == skvt_pkg::CTRL_ACT)
		else $error("cell shift commanded outside the act phase");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds table depth");

	a_cmp_then_act: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skvt_pkg::CTRL_CMP |=> state_q == skvt_pkg::CTRL_ACT)
		else $error("compare phase not followed by act phase");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == skvt_pkg::OP_INSERT |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not advance the entry count");

endmodule

// File: design/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// Sorted key/value table
// A table of up to DEPTH key/value entries kept in ascending key order,
// serving insert, find and remove requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request with a
// defined type produces exactly one result, shown on result for one cycle with
// done high; the receiver must take it then, since the block cannot hold it.
// A request of the unused type is taken and produces no result. Each request
// passes a compare phase and then an act phase: in the first every cell
// compares its stored key with the request key and registers the outcome,
// in the second the flags of all cells are merged, the controller decides
// the result for the result register and, on an insert that succeeds or a
// remove that hits, every cell at or above the key's position shifts by one
// place. busy is high only during the compare cycle, so a new request can be
// transferred in the cycle its predecessor acts. Entries are ordered by
// unsigned key, which for packed byte strings with the first character most
// significant is lexicographic order; only the low KEY_WIDTH bits of the key
// take part. position reports the low ten bits of the sorted index, and
// found_value is zero on every result but a hit on find. The table starts
// empty after reset with no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_value_table #(
	parameter int DEPTH     = 1024,
	parameter int KEY_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  skvt_pkg::req_t    req,
	output logic              done,
	output skvt_pkg::result_t result
);

	localparam int IW = $clog2(DEPTH);

	// Request held for the compare and act phases.
	logic [KEY_WIDTH-1:0]         req_key_q;
	logic [skvt_pkg::VALUE_W-1:0] req_value_q;
	skvt_pkg::req_type_t          req_type_q;

	logic                  accept;
	logic                  ctrl_busy;
	skvt_pkg::cell_cmd_t   cmd;
	skvt_pkg::act_result_t act;

	// Row of cells and the links between neighbors.
	logic [KEY_WIDTH-1:0]         cell_key   [DEPTH];
	logic [skvt_pkg::VALUE_W-1:0] cell_value [DEPTH];
	logic [DEPTH-1:0]             cell_occ;
	logic [DEPTH-1:0]             cell_lt;
	logic [DEPTH-1:0]             cell_eq;
	logic [DEPTH-1:0]             cell_bnd;

	// Merged outcome of the compare phase.
	logic                         hit;
	logic [IW-1:0]                hit_pos;
	logic [skvt_pkg::VALUE_W-1:0] hit_value;

	logic                         done_q;
	skvt_pkg::result_t            result_q;

	assign accept = start && !ctrl_busy;
	assign busy   = ctrl_busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_key_q   <= req.key[KEY_WIDTH-1:0];
			req_value_q <= req.value;
			req_type_q  <= req.req_type;
		end
	end

	skvt_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type_q),
		.hit      (hit),
		.busy     (ctrl_busy),
		.cmd      (cmd),
		.act      (act)
	);

	// Cell zero sees an always-less, always-occupied neighbor below it, so it
	// is the boundary whenever its own key is not below the request key. The
	// top cell pulls in an empty entry on remove.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [KEY_WIDTH-1:0]         l_key;
		logic [skvt_pkg::VALUE_W-1:0] l_value;
		logic                         l_occ;
		logic                         l_lt;
		logic [KEY_WIDTH-1:0]         r_key;
		logic [skvt_pkg::VALUE_W-1:0] r_value;
		logic                         r_occ;

		if (g == 0) begin : g_first
			assign l_key   = '0;
			assign l_value = '0;
			assign l_occ   = 1'b1;
			assign l_lt    = 1'b1;
		end else begin : g_mid_lo
			assign l_key   = cell_key[g-1];
			assign l_value = cell_value[g-1];
			assign l_occ   = cell_occ[g-1];
			assign l_lt    = cell_lt[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign r_key   = '0;
			assign r_value = '0;
			assign r_occ   = 1'b0;
		end else begin : g_mid_hi
			assign r_key   = cell_key[g+1];
			assign r_value = cell_value[g+1];
			assign r_occ   = cell_occ[g+1];
		end

		skvt_cell #(
			.KEY_WIDTH (KEY_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.req_key     (req_key_q),
			.req_value   (req_value_q),
			.left_key    (l_key),
			.left_value  (l_value),
			.left_occ    (l_occ),
			.left_lt     (l_lt),
			.right_key   (r_key),
			.right_value (r_value),
			.right_occ   (r_occ),
			.key         (cell_key[g]),
			.value       (cell_value[g]),
			.occ         (cell_occ[g]),
			.lt          (cell_lt[g]),
			.eq          (cell_eq[g]),
			.boundary    (cell_bnd[g])
		);
	end

	// At most one cell is the boundary, so its index and payload are gathered
	// with a plain OR over the row. With every entry below the key there is
	// no boundary; that only happens on a full table, where no position is
	// reported.
	always_comb begin
		hit       = 1'b0;
		hit_pos   = '0;
		hit_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_bnd[i]) begin
				hit_pos = hit_pos | IW'(i);
			end
			if (cell_bnd[i] && cell_eq[i]) begin
				hit       = 1'b1;
				hit_value = hit_value | cell_value[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= act.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (act.emit) begin
			result_q.status      <= act.status;
			result_q.position    <= act.pos_en ? skvt_pkg::POS_W'(hit_pos) : '0;
			result_q.found_value <= act.val_en ? hit_value : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_single_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_bnd))
		else $error("more than one boundary cell in the table");

	a_value_only_on_found: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (result_q.found_value == '0
			|| result_q.status == skvt_pkg::STATUS_FOUND))
		else $error("payload reported on a result other than found");

endmodule
